[sv/r4scg_pkg.sv]
package r4scg_pkg;

    localparam int MAX_DEVICES_DEF = 16;
    localparam int OFFSET_BITS_DEF = 48;

    localparam int OFF_W   = 48;
    localparam int LEN_W   = 21;
    localparam int DEV_W   = 4;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 2;

    localparam logic [LEN_W-1:0] MAX_BLOCK = LEN_W'(1048576);

    localparam logic [IDX_W-1:0] REG_BLOCK_BYTES  = 2'd0;
    localparam logic [IDX_W-1:0] REG_DATA_DEVICES = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEGRADED     = 2'd2;
    localparam logic [IDX_W-1:0] REG_MISSING      = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        CMD_READ_HOST   = 3'd0,
        CMD_READ_XOR    = 3'd1,
        CMD_XOR_HOST    = 3'd2,
        CMD_WRITE_HOST  = 3'd3,
        CMD_WRITE_ACC   = 3'd4,
        CMD_DELIVER_ACC = 3'd5,
        CMD_CLEAR_ACC   = 3'd6
    } cmd_kind_t;

    typedef struct packed {
        logic             opcode;
        logic [DEV_W-1:0] dev;
        logic [OFF_W-1:0] doff;
        logic [LEN_W-1:0] len;
    } seq_item_t;

    typedef struct packed {
        logic [DEV_W-1:0] nd;
        logic             degraded;
        logic [DEV_W-1:0] missing;
    } seq_cfg_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        cmd_kind_t        kind;
        logic             last;
    } cmd_t;

endpackage

[sv/r4scg_div_cell.sv]
// One restoring division step: brings in the next dividend bit and decides one quotient bit.
module r4scg_div_cell #(
    parameter int AW = 48,
    parameter int DW = 21,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [AW-1:0] in_num,
    input  logic [AW-1:0] in_q,
    input  logic [PW-1:0] in_pay,
    input  logic [DW-1:0] divisor,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [AW-1:0] out_num,
    output logic [AW-1:0] out_q,
    output logic [PW-1:0] out_pay
);

    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;
    logic        valid_reg;
    logic [DW-1:0] rem_reg;
    logic [AW-1:0] num_reg;
    logic [AW-1:0] q_reg;
    logic [PW-1:0] pay_reg;

    always_comb
    begin
        trial = {in_rem, in_num[AW-1]};
        ge    = (trial >= {1'b0, divisor});
        diff  = trial - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            num_reg <= {in_num[AW-2:0], 1'b0};
            q_reg   <= {in_q[AW-2:0], ge};
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_q     = q_reg;
    assign out_pay   = pay_reg;

endmodule

[sv/r4scg_div_chain.sv]
// Row of AW division cells; quotient and remainder leave the last cell.
module r4scg_div_chain #(
    parameter int AW = 48,
    parameter int DW = 21,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [AW-1:0] in_num,
    input  logic [PW-1:0] in_pay,
    input  logic [DW-1:0] divisor,
    output logic          out_valid,
    output logic [AW-1:0] out_q,
    output logic [DW-1:0] out_rem,
    output logic [PW-1:0] out_pay
);

    logic          v   [AW+1];
    logic [DW-1:0] rem [AW+1];
    logic [AW-1:0] num [AW+1];
    logic [AW-1:0] q   [AW+1];
    logic [PW-1:0] pay [AW+1];

    assign v[0]   = in_valid;
    assign rem[0] = '0;
    assign num[0] = in_num;
    assign q[0]   = '0;
    assign pay[0] = in_pay;

    for (genvar k = 0; k < AW; k++)
    begin : g_cell
        r4scg_div_cell #(.AW(AW), .DW(DW), .PW(PW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v[k]),
            .in_rem   (rem[k]),
            .in_num   (num[k]),
            .in_q     (q[k]),
            .in_pay   (pay[k]),
            .divisor  (divisor),
            .out_valid(v[k+1]),
            .out_rem  (rem[k+1]),
            .out_num  (num[k+1]),
            .out_q    (q[k+1]),
            .out_pay  (pay[k+1])
        );
    end

    assign out_valid = v[AW];
    assign out_q     = q[AW];
    assign out_rem   = rem[AW];
    assign out_pay   = pay[AW];

endmodule

[sv/r4scg_seq.sv]
// Command sequencer with an output register.
module r4scg_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  r4scg_pkg::seq_item_t in_item,
    input  r4scg_pkg::seq_cfg_t  cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output r4scg_pkg::cmd_t      out_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CLEAR, S_LOOP, S_RDATA, S_RPAR,
        S_XOR, S_WHOST, S_WACC, S_DELIVER
    } state_t;

    state_t                        state_reg, state_next, first_state;
    logic [r4scg_pkg::DEV_W-1:0]   i_reg, i_next;
    r4scg_pkg::seq_item_t          item_reg;
    logic                          miss_data_reg, miss_par_reg;
    logic                          out_valid_reg;
    r4scg_pkg::cmd_t               cmd_reg, cur;
    logic                          adv, skip, emit, loop_end;
    logic                          in_miss_data, in_miss_par;

    assign adv  = !out_valid_reg || out_ready;
    assign skip = (state_reg == S_LOOP) && (i_reg == cfg.missing);
    assign emit = (state_reg != S_IDLE) && !skip;
    assign loop_end = item_reg.opcode ? (i_reg == cfg.nd - 4'd1) : (i_reg == cfg.nd);
    assign in_ready = (state_reg == S_IDLE) || (adv && emit && cur.last);

    assign in_miss_data = cfg.degraded && (cfg.missing == in_item.dev);
    assign in_miss_par  = cfg.degraded && (cfg.missing == cfg.nd);

    always_comb
    begin
        cur.dev  = item_reg.dev;
        cur.off  = item_reg.doff;
        cur.len  = item_reg.len;
        cur.kind = r4scg_pkg::CMD_READ_HOST;
        cur.last = 1'b0;
        state_next = state_reg;
        i_next = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_READ:
            begin
                cur.last = 1'b1;
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                cur.kind = r4scg_pkg::CMD_CLEAR_ACC;
                state_next = miss_data_reg ? S_LOOP : S_RDATA;
                i_next = '0;
            end
            S_LOOP:
            begin
                cur.dev  = i_reg;
                cur.kind = r4scg_pkg::CMD_READ_XOR;
                i_next = i_reg + 4'd1;
                if (loop_end)
                begin
                    state_next = item_reg.opcode ? S_XOR : S_DELIVER;
                end
            end
            S_RDATA:
            begin
                cur.kind = r4scg_pkg::CMD_READ_XOR;
                state_next = S_RPAR;
            end
            S_RPAR:
            begin
                cur.dev  = cfg.nd;
                cur.kind = r4scg_pkg::CMD_READ_XOR;
                state_next = S_XOR;
            end
            S_XOR:
            begin
                cur.kind = r4scg_pkg::CMD_XOR_HOST;
                state_next = miss_data_reg ? S_WACC : S_WHOST;
            end
            S_WHOST:
            begin
                cur.kind = r4scg_pkg::CMD_WRITE_HOST;
                cur.last = miss_par_reg;
                state_next = miss_par_reg ? S_IDLE : S_WACC;
            end
            S_WACC:
            begin
                cur.dev  = cfg.nd;
                cur.kind = r4scg_pkg::CMD_WRITE_ACC;
                cur.last = 1'b1;
                state_next = S_IDLE;
            end
            S_DELIVER:
            begin
                cur.kind = r4scg_pkg::CMD_DELIVER_ACC;
                cur.last = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (in_item.len == '0)
        begin
            first_state = S_IDLE;
        end
        else if (!in_item.opcode)
        begin
            first_state = in_miss_data ? S_CLEAR : S_READ;
        end
        else
        begin
            first_state = (!in_miss_data && in_miss_par) ? S_WHOST : S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= emit;
                if (emit)
                begin
                    cmd_reg <= cur;
                end
                i_reg <= i_next;
            end
            // A new chunk replaces the finished sequence in the same cycle.
            if (in_ready && in_valid)
            begin
                item_reg      <= in_item;
                miss_data_reg <= in_miss_data;
                miss_par_reg  <= in_miss_par;
                state_reg     <= first_state;
            end
            else if (adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cmd   = cmd_reg;

endmodule

[sv/raid4_stripe_command_generator_core.sv]
// Channel   Direction  Transfer contents
// s_*       in         tdata: byte_offset, chunk_length; tuser: opcode
// m_*       out        tdata: device_index, device_offset, transfer_length;
//                      tuser: command_kind; tlast: last_command
// cfg_*     in         register index and data, written when cfg_we is high
//
// A chunk passes two rows of division cells (address by block size, then
// stripe by data disk count), one quotient bit per cell, and two multiply
// and add stages. While m_tready is high the sequencer then emits one
// command a cycle, with none at the missing disk's loop step: one for a
// read, six for a normal write, up to N+2 for a degraded case and none for
// a zero length chunk. The sequencer sets the sustained rate.
// Reset clears every valid bit and the registers to their defaults.
// A stall holds the pipeline once its last stage is full; s_tready falls.
module raid4_stripe_command_generator_core #(
    parameter int MAX_DEVICES = r4scg_pkg::MAX_DEVICES_DEF,
    parameter int OFFSET_BITS = r4scg_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [47:0] byte_offset, [68:48] chunk_length
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [3:0] device_index, [51:4] device_offset,
                                   // [72:52] transfer_length
    output logic [2:0]  m_tuser,   // [2:0] command_kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [r4scg_pkg::IDX_W-1:0] cfg_index,
    input  logic [r4scg_pkg::LEN_W-1:0] cfg_data
);

    // Address width actually used; the offset field itself stays 48 bits.
    localparam int AW = (OFFSET_BITS < r4scg_pkg::OFF_W) ? OFFSET_BITS : r4scg_pkg::OFF_W;
    localparam int H  = (AW + 1) / 2;
    localparam int HW = AW - H;
    localparam int LW = r4scg_pkg::LEN_W;
    localparam int DV = r4scg_pkg::DEV_W;
    localparam logic [DV-1:0] ND_MAX = DV'(MAX_DEVICES - 1);

    logic [LW-1:0] block_bytes_reg;
    logic [DV-1:0] data_devices_reg;
    logic          degraded_reg;
    logic [DV-1:0] missing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg  <= LW'(4096);
            data_devices_reg <= DV'(2);
            degraded_reg     <= 1'b0;
            missing_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                r4scg_pkg::REG_BLOCK_BYTES:  block_bytes_reg  <= cfg_data;
                r4scg_pkg::REG_DATA_DEVICES: data_devices_reg <= cfg_data[DV-1:0];
                r4scg_pkg::REG_DEGRADED:     degraded_reg     <= cfg_data[0];
                r4scg_pkg::REG_MISSING:      missing_reg      <= cfg_data[DV-1:0];
                default:                     ;
            endcase
        end
    end

    // Effective geometry: block size clamped to 1..1 MiB, disk count to 2..MAX-1.
    logic [LW-1:0] bsz;
    logic [DV-1:0] nd;
    always_comb
    begin
        if (block_bytes_reg == '0)
            bsz = LW'(1);
        else if (block_bytes_reg > r4scg_pkg::MAX_BLOCK)
            bsz = r4scg_pkg::MAX_BLOCK;
        else
            bsz = block_bytes_reg;
        if (data_devices_reg < DV'(2))
            nd = DV'(2);
        else if (data_devices_reg > ND_MAX)
            nd = ND_MAX;
        else
            nd = data_devices_reg;
    end

    logic          en;
    logic [AW-1:0] in_addr;
    logic [LW-1:0] in_len, len_eff;

    assign in_addr = s_tdata[AW-1:0];
    assign in_len  = s_tdata[68:48];
    assign len_eff = (in_len > bsz) ? bsz : in_len;
    assign s_tready = en;

    // First row: stripe = address / block size, remainder is the offset in the unit.
    logic          d1_valid;
    logic [AW-1:0] d1_q;
    logic [LW-1:0] d1_rem;
    logic [LW:0]   d1_pay;

    r4scg_div_chain #(.AW(AW), .DW(LW), .PW(LW + 1)) u_div_blk (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_num   (in_addr),
        .in_pay   ({s_tuser[0], len_eff}),
        .divisor  (bsz),
        .out_valid(d1_valid),
        .out_q    (d1_q),
        .out_rem  (d1_rem),
        .out_pay  (d1_pay)
    );

    // Second row: stripe / disk count gives the row, the remainder the data disk.
    logic            d2_valid;
    logic [AW-1:0]   d2_q;
    logic [DV-1:0]   d2_rem;
    logic [2*LW:0]   d2_pay;

    r4scg_div_chain #(.AW(AW), .DW(DV), .PW(2 * LW + 1)) u_div_dev (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d1_valid),
        .in_num   (d1_q),
        .in_pay   ({d1_pay, d1_rem}),
        .divisor  (nd),
        .out_valid(d2_valid),
        .out_q    (d2_q),
        .out_rem  (d2_rem),
        .out_pay  (d2_pay)
    );

    // Row times block size in two halves, then the sum with the unit offset.
    logic              m1_valid_reg;
    logic [H+LW-1:0]   p_lo_reg;
    logic [HW-1:0]     p_hi_reg;
    logic [HW+LW-1:0]  p_hi_full;
    logic [2*LW:0]     m1_pay_reg;
    logic [DV-1:0]     m1_dev_reg;
    logic              m2_valid_reg;
    r4scg_pkg::seq_item_t m2_item_reg;
    logic [AW-1:0]     doff_sum;
    logic              seq_ready;

    assign p_hi_full = d2_q[AW-1:H] * bsz;
    assign doff_sum  = AW'(p_lo_reg) + {p_hi_reg, {H{1'b0}}} + AW'(m1_pay_reg[LW-1:0]);
    assign en = !(m2_valid_reg && !seq_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= d2_valid;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg          <= d2_q[H-1:0] * bsz;
            p_hi_reg          <= p_hi_full[HW-1:0];
            m1_pay_reg        <= d2_pay;
            m1_dev_reg        <= d2_rem;
            m2_item_reg.opcode <= m1_pay_reg[2*LW];
            m2_item_reg.len    <= m1_pay_reg[2*LW-1:LW];
            m2_item_reg.dev    <= m1_dev_reg;
            m2_item_reg.doff   <= r4scg_pkg::OFF_W'(doff_sum);
        end
    end

    r4scg_pkg::seq_cfg_t seq_cfg;
    r4scg_pkg::cmd_t     cmd;

    assign seq_cfg.nd       = nd;
    assign seq_cfg.degraded = degraded_reg;
    assign seq_cfg.missing  = missing_reg;

    r4scg_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m2_valid_reg),
        .in_ready (seq_ready),
        .in_item  (m2_item_reg),
        .cfg      (seq_cfg),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_cmd  (cmd)
    );

    assign m_tdata = {7'd0, cmd.len, cmd.off, cmd.dev};
    assign m_tuser = cmd.kind;
    assign m_tlast = cmd.last;

    // The pipeline must hold whenever its last stage cannot hand over.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m2_valid_reg && !seq_ready) |-> !s_tready)
        else $error("input taken while pipeline is stalled");

    // Only a terminating command kind may close a chunk.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (cmd.kind == r4scg_pkg::CMD_READ_HOST
            || cmd.kind == r4scg_pkg::CMD_WRITE_HOST
            || cmd.kind == r4scg_pkg::CMD_WRITE_ACC
            || cmd.kind == r4scg_pkg::CMD_DELIVER_ACC))
        else $error("last flag on a non-terminal command");

    // A clear always opens a sequence, so it must never be marked last.
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !(m_tvalid && m_tlast
            && cmd.kind == r4scg_pkg::CMD_CLEAR_ACC))
        else $error("clear command marked last");

endmodule
